FILE: rtl/ir_halfbit_frame_transmitter_macros.svh
// Assertion macros shared by the transmitter RTL files.
`ifndef IR_HALFBIT_FRAME_TRANSMITTER_MACROS_SVH
`define IR_HALFBIT_FRAME_TRANSMITTER_MACROS_SVH

// A property that is checked on every clock edge outside reset.
`define IRHFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that implies a consequence in the next cycle.
`define IRHFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/irhft_pkg.sv
// Types, constants and helpers of the infrared half-bit frame transmitter.
`timescale 1ns / 1ps

package irhft_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int QCOUNT_W    = 3;

  localparam int FRAME_W     = 48;
  localparam int EXT_BIT     = FRAME_W - 1;
  localparam int BITPOS_W    = 6;
  localparam int LEN_W       = 6;
  localparam int GAP_W       = 8;
  localparam int CFG_W       = 8;
  localparam int CFG_IDX_W   = 2;

  localparam logic [GAP_W-1:0] GAP_MAX             = 8'hFF;
  localparam logic [GAP_W-1:0] GAP_THRESHOLD_RST   = 8'd128;
  localparam logic [LEN_W-1:0] SHORT_LENGTH_RST    = 6'd29;
  localparam logic [LEN_W-1:0] EXTENDED_LENGTH_RST = 6'd45;
  localparam logic [LEN_W-1:0] LEN_MAX             = 6'd48;
  localparam logic [LEN_W-1:0] LEN_MIN             = 6'd1;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_ENQUEUE = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAP_THRESHOLD   = 2'd0,
    CFG_SHORT_LENGTH    = 2'd1,
    CFG_EXTENDED_LENGTH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [FRAME_W-1:0]   frame_bits;
    logic                 hold_repeat;
  } in_item_t;

  typedef struct packed {
    logic                 ir_level;
    logic                 sending;
    logic                 held_start;
    logic                 put_accepted;
    logic [QCOUNT_W-1:0]  queue_count;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] count_nxt;
    logic               full;
    logic               empty;
  } fifo_status_t;

  // A length of zero acts as one half-bit, anything above a full frame as a full frame.
  function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    if (len == '0) begin
      res = LEN_MIN;
    end else if (len > LEN_MAX) begin
      res = LEN_MAX;
    end else begin
      res = len;
    end
    return res;
  endfunction

endpackage

FILE: rtl/irhft_fifo.sv
// Frame queue: a small circular buffer of pre-encoded frames.
`timescale 1ns / 1ps
`include "ir_halfbit_frame_transmitter_macros.svh"

module irhft_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  irhft_pkg::fifo_ctl_t          ctl,
  input  logic [irhft_pkg::FRAME_W-1:0] wr_data,
  output logic [irhft_pkg::FRAME_W-1:0] head,
  output irhft_pkg::fifo_status_t       status
);

  logic [irhft_pkg::FRAME_W-1:0] store [irhft_pkg::QUEUE_DEPTH];

  logic [irhft_pkg::IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [irhft_pkg::IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [irhft_pkg::COUNT_W-1:0] count_r, count_nxt;

  localparam logic [irhft_pkg::IDX_W-1:0]   LAST_IDX =
    irhft_pkg::IDX_W'(irhft_pkg::QUEUE_DEPTH - 1);
  localparam logic [irhft_pkg::COUNT_W-1:0] FULL_COUNT =
    irhft_pkg::COUNT_W'(irhft_pkg::QUEUE_DEPTH);

  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    count_nxt  = count_r;
    if (ctl.push) begin
      wr_idx_nxt = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end
    if (ctl.pop) begin
      rd_idx_nxt = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      count_r  <= '0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entries hold no reset value; the count keeps unwritten entries from being read.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      store[wr_idx_r] <= wr_data;
    end
  end

  assign head             = store[rd_idx_r];
  assign status.count     = count_r;
  assign status.count_nxt = count_nxt;
  assign status.full      = (count_r == FULL_COUNT);
  assign status.empty     = (count_r == '0);

  `IRHFT_ASSERT(a_count_bound, count_r <= FULL_COUNT, "frame queue count above depth")
  `IRHFT_ASSERT(a_no_push_full, !(ctl.push && (count_r == FULL_COUNT)), "push into full queue")
  `IRHFT_ASSERT(a_no_pop_empty, !(ctl.pop && (count_r == '0)), "pop from empty queue")

endmodule

FILE: rtl/ir_halfbit_frame_transmitter.sv
// Infrared half-bit frame transmitter top level.
`timescale 1ns / 1ps
`include "ir_halfbit_frame_transmitter_macros.svh"

// Each input transfer is either a timer tick or the enqueue of one six-byte
// pre-encoded frame. Every accepted transfer yields exactly one result, which
// appears in the output register on the following cycle, and a new transfer
// is accepted in every cycle: the throughput is one item per clock, and the
// only thing that holds the input is a result left waiting in the output
// register while the consumer stalls. On a tick the block starts a queued
// frame when it is idle and the gap counter exceeds gap_threshold, then drives
// one half-bit, LSB of byte 0 first; a frame lasts short_length half-bits, or
// extended_length when bit 47 is set. A frame started with hold_repeat set
// stays queued and raises held_start. Frames offered to a full queue are
// dropped with put_accepted low. Configuration writes take effect at once and
// should only be made while no result is outstanding.
module ir_halfbit_frame_transmitter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  irhft_pkg::in_item_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output irhft_pkg::out_item_t            out_data,
  input  logic                            cfg_we,
  input  logic [irhft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irhft_pkg::CFG_W-1:0]     cfg_wdata
);

  // Configuration registers
  logic [irhft_pkg::GAP_W-1:0] gap_threshold_r;
  logic [irhft_pkg::LEN_W-1:0] short_length_r;
  logic [irhft_pkg::LEN_W-1:0] extended_length_r;

  // Transmit state
  logic [irhft_pkg::FRAME_W-1:0]  frame_r, frame_nxt;
  logic [irhft_pkg::BITPOS_W-1:0] bitpos_r, bitpos_nxt;
  logic [irhft_pkg::LEN_W-1:0]    hbcount_r, hbcount_nxt;
  logic                           ext_r, ext_nxt;
  logic                           active_r, active_nxt;
  logic [irhft_pkg::GAP_W-1:0]    gap_r, gap_nxt;

  logic                 out_valid_r, out_valid_nxt;
  irhft_pkg::out_item_t out_r, out_nxt;

  irhft_pkg::fifo_ctl_t          fifo_ctl;
  irhft_pkg::fifo_status_t       fifo_status;
  logic [irhft_pkg::FRAME_W-1:0] fifo_head;

  logic                           in_accept;
  logic                           start;
  logic [irhft_pkg::FRAME_W-1:0]  cur_frame;
  logic [irhft_pkg::BITPOS_W-1:0] cur_bitpos;
  logic [irhft_pkg::LEN_W-1:0]    cur_hbcount;
  logic [irhft_pkg::LEN_W-1:0]    hbcount_inc;
  logic                           cur_ext;
  logic                           cur_active;
  logic [irhft_pkg::LEN_W-1:0]    frame_len;
  logic                           level;

  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  irhft_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fifo_ctl),
    .wr_data (in_data.frame_bits),
    .head    (fifo_head),
    .status  (fifo_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_threshold_r   <= irhft_pkg::GAP_THRESHOLD_RST;
      short_length_r    <= irhft_pkg::SHORT_LENGTH_RST;
      extended_length_r <= irhft_pkg::EXTENDED_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        irhft_pkg::CFG_GAP_THRESHOLD:   gap_threshold_r   <= cfg_wdata;
        irhft_pkg::CFG_SHORT_LENGTH:    short_length_r    <= cfg_wdata[irhft_pkg::LEN_W-1:0];
        irhft_pkg::CFG_EXTENDED_LENGTH: extended_length_r <= cfg_wdata[irhft_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A frame starting on this tick is driven from its first half-bit in the same tick.
  always_comb begin
    start = (in_data.opcode == irhft_pkg::OP_TICK) && !active_r &&
            !fifo_status.empty && (gap_r > gap_threshold_r);

    cur_frame   = start ? fifo_head : frame_r;
    cur_ext     = start ? fifo_head[irhft_pkg::EXT_BIT] : ext_r;
    cur_bitpos  = start ? '0 : bitpos_r;
    cur_hbcount = start ? '0 : hbcount_r;
    cur_active  = start | active_r;

    frame_len   = irhft_pkg::eff_length(cur_ext ? extended_length_r : short_length_r);
    hbcount_inc = cur_hbcount + irhft_pkg::LEN_W'(1);
    level       = (cur_bitpos < irhft_pkg::BITPOS_W'(irhft_pkg::FRAME_W)) ?
                  cur_frame[cur_bitpos] : 1'b0;
  end

  always_comb begin
    fifo_ctl.push = 1'b0;
    fifo_ctl.pop  = 1'b0;
    frame_nxt     = frame_r;
    bitpos_nxt    = bitpos_r;
    hbcount_nxt   = hbcount_r;
    ext_nxt       = ext_r;
    active_nxt    = active_r;
    gap_nxt       = gap_r;
    out_nxt       = out_r;

    if (in_accept) begin
      out_nxt.ir_level     = 1'b0;
      out_nxt.sending      = active_r;
      out_nxt.held_start   = 1'b0;
      out_nxt.put_accepted = 1'b0;

      unique case (in_data.opcode)
        irhft_pkg::OP_ENQUEUE: begin
          fifo_ctl.push        = !fifo_status.full;
          out_nxt.put_accepted = !fifo_status.full;
        end
        irhft_pkg::OP_TICK: begin
          fifo_ctl.pop       = start && !in_data.hold_repeat;
          out_nxt.held_start = start && in_data.hold_repeat;
          frame_nxt          = cur_frame;
          ext_nxt            = cur_ext;
          bitpos_nxt         = cur_bitpos;
          hbcount_nxt        = cur_hbcount;
          active_nxt         = cur_active;
          out_nxt.sending    = cur_active;
          if (cur_active) begin
            out_nxt.ir_level = level;
            bitpos_nxt       = cur_bitpos + irhft_pkg::BITPOS_W'(1);
            hbcount_nxt      = hbcount_inc;
            active_nxt       = !(hbcount_inc >= frame_len);
          end
          // Starting a frame clears the gap counter before this tick's increment.
          if (start) begin
            gap_nxt = irhft_pkg::GAP_W'(1);
          end else if (gap_r != irhft_pkg::GAP_MAX) begin
            gap_nxt = gap_r + irhft_pkg::GAP_W'(1);
          end
        end
        default: ;
      endcase

      out_nxt.queue_count = irhft_pkg::QCOUNT_W'(fifo_status.count_nxt);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r     <= '0;
      bitpos_r    <= '0;
      hbcount_r   <= '0;
      ext_r       <= 1'b0;
      active_r    <= 1'b0;
      gap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      frame_r     <= frame_nxt;
      bitpos_r    <= bitpos_nxt;
      hbcount_r   <= hbcount_nxt;
      ext_r       <= ext_nxt;
      active_r    <= active_nxt;
      gap_r       <= gap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `IRHFT_ASSERT(a_held_implies_sending, !(out_valid_r && out_r.held_start) || out_r.sending, "held start without sending")
  `IRHFT_ASSERT(a_active_count_bound, !active_r || (hbcount_r < irhft_pkg::LEN_MAX), "half-bit count past frame end")
  `IRHFT_ASSERT_NEXT(a_start_clears_gap, in_accept && start, gap_r == irhft_pkg::GAP_W'(1), "gap counter not restarted")
  `IRHFT_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid_r, "accepted transfer produced no result")

endmodule

FILE: sim/ir_halfbit_frame_transmitter_test.sv
// Self-checking testbench of the infrared half-bit frame transmitter.
`timescale 1ns / 1ps

module ir_halfbit_frame_transmitter_test;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  irhft_pkg::in_item_t             in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  irhft_pkg::out_item_t            out_data;
  logic                            cfg_we    = 1'b0;
  logic [irhft_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [irhft_pkg::CFG_W-1:0]     cfg_wdata = '0;

  ir_halfbit_frame_transmitter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted state of the transmitter.
  logic [irhft_pkg::FRAME_W-1:0] q_store [irhft_pkg::QUEUE_DEPTH];
  int                            q_wr;
  int                            q_rd;
  int                            q_count;
  logic [irhft_pkg::FRAME_W-1:0] tx_frame;
  int                            tx_pos;
  int                            tx_halfbits;
  logic                          tx_ext;
  logic                          tx_active;
  logic [irhft_pkg::GAP_W-1:0]   gap_count;
  logic [irhft_pkg::GAP_W-1:0]   cfg_gap;
  logic [irhft_pkg::LEN_W-1:0]   cfg_short_len;
  logic [irhft_pkg::LEN_W-1:0]   cfg_ext_len;

  irhft_pkg::out_item_t expected_tx_status [$];
  int                   failures       = 0;
  int                   send_idle_pct  = 0;
  int                   recv_stall_pct = 0;
  int                   holdoff_req    = 0;
  int                   holdoff_left   = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void reset_tx_model();
    q_wr          = 0;
    q_rd          = 0;
    q_count       = 0;
    tx_frame      = '0;
    tx_pos        = 0;
    tx_halfbits   = 0;
    tx_ext        = 1'b0;
    tx_active     = 1'b0;
    gap_count     = '0;
    cfg_gap       = irhft_pkg::GAP_THRESHOLD_RST;
    cfg_short_len = irhft_pkg::SHORT_LENGTH_RST;
    cfg_ext_len   = irhft_pkg::EXTENDED_LENGTH_RST;
  endfunction

  // Advances the predicted state by one transfer and returns the status it produces.
  function automatic irhft_pkg::out_item_t tx_step(input irhft_pkg::in_item_t item);
    irhft_pkg::out_item_t res;
    int unsigned          len;
    res = '0;
    if (item.opcode == irhft_pkg::OP_ENQUEUE) begin
      if (q_count < irhft_pkg::QUEUE_DEPTH) begin
        q_store[irhft_pkg::IDX_W'(q_wr)] = item.frame_bits;
        q_wr = (q_wr + 1) % irhft_pkg::QUEUE_DEPTH;
        q_count++;
        res.put_accepted = 1'b1;
      end
      res.sending = tx_active;
    end else begin
      if (!tx_active && q_count > 0 && gap_count > cfg_gap) begin
        tx_active   = 1'b1;
        tx_halfbits = 0;
        tx_pos      = 0;
        gap_count   = '0;
        tx_frame    = q_store[irhft_pkg::IDX_W'(q_rd)];
        tx_ext      = tx_frame[irhft_pkg::EXT_BIT];
        if (item.hold_repeat) begin
          res.held_start = 1'b1;
        end else begin
          q_rd = (q_rd + 1) % irhft_pkg::QUEUE_DEPTH;
          q_count--;
        end
      end
      if (tx_active) begin
        len = 32'(tx_ext ? cfg_ext_len : cfg_short_len);
        if (len == 0) begin
          len = 1;
        end else if (len > irhft_pkg::FRAME_W) begin
          len = irhft_pkg::FRAME_W;
        end
        res.ir_level = tx_frame[irhft_pkg::BITPOS_W'(tx_pos)];
        res.sending  = 1'b1;
        tx_pos++;
        tx_halfbits++;
        if (tx_halfbits >= len) begin
          tx_active = 1'b0;
        end
      end
      if (gap_count < irhft_pkg::GAP_MAX) begin
        gap_count++;
      end
    end
    res.queue_count = irhft_pkg::QCOUNT_W'(q_count);
    return res;
  endfunction

  function automatic irhft_pkg::in_item_t tick_item(input logic hold);
    irhft_pkg::in_item_t item;
    item             = '0;
    item.opcode      = irhft_pkg::OP_TICK;
    item.hold_repeat = hold;
    return item;
  endfunction

  function automatic irhft_pkg::in_item_t enqueue_item(
    input logic [irhft_pkg::FRAME_W-1:0] bits
  );
    irhft_pkg::in_item_t item;
    item            = '0;
    item.opcode     = irhft_pkg::OP_ENQUEUE;
    item.frame_bits = bits;
    return item;
  endfunction

  function automatic irhft_pkg::in_item_t random_item(input int enq_pct, input int hold_pct);
    irhft_pkg::in_item_t item;
    item.opcode            = ($urandom_range(99) < enq_pct) ? irhft_pkg::OP_ENQUEUE :
                             irhft_pkg::OP_TICK;
    item.frame_bits[31:0]  = $urandom;
    item.frame_bits[47:32] = 16'($urandom);
    item.hold_repeat       = ($urandom_range(99) < hold_pct);
    return item;
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happened.
  task automatic send_item(input irhft_pkg::in_item_t item);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    expected_tx_status.push_back(tx_step(item));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_tx_status.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes all three registers on consecutive edges; the block must be idle.
  task automatic set_config(input logic [irhft_pkg::CFG_W-1:0] gap,
                            input logic [irhft_pkg::CFG_W-1:0] short_v,
                            input logic [irhft_pkg::CFG_W-1:0] ext_v);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= irhft_pkg::CFG_GAP_THRESHOLD;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_index <= irhft_pkg::CFG_SHORT_LENGTH;
    cfg_wdata <= short_v;
    @(posedge clk);
    cfg_index <= irhft_pkg::CFG_EXTENDED_LENGTH;
    cfg_wdata <= ext_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_gap       = gap;
    cfg_short_len = short_v[irhft_pkg::LEN_W-1:0];
    cfg_ext_len   = ext_v[irhft_pkg::LEN_W-1:0];
  endtask

  // Splits the items over the three idling patterns: receiver-heavy gaps, sender-heavy
  // gaps, and none at all.
  task automatic run_random(input int count, input int enq_pct, input int hold_pct);
    for (int i = 0; i < count; i++) begin
      if (i < count / 3) begin
        send_idle_pct  = 37;
        recv_stall_pct = 86;
      end else if (i < 2 * count / 3) begin
        send_idle_pct  = 86;
        recv_stall_pct = 37;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      send_item(random_item(enq_pct, hold_pct));
    end
  endtask

  // Reset register values: a frame needs more than 128 gap ticks before it starts.
  task automatic test_reset_defaults();
    send_idle_pct  = 37;
    recv_stall_pct = 86;
    send_item(enqueue_item(48'h8000_1234_5678));
    send_item(enqueue_item(48'h0000_9ABC_DEF0));
    for (int i = 0; i < 150; i++) begin
      send_item(tick_item(1'b0));
    end
  endtask

  task automatic test_directed();
    set_config(8'd0, 8'd4, 8'd6);
    send_idle_pct  = 37;
    recv_stall_pct = 86;
    send_item(tick_item(1'b0));
    send_item(enqueue_item(48'h0000_0000_0000));
    send_item(enqueue_item(48'hFFFF_FFFF_FFFF));
    send_item(enqueue_item(48'h5555_5555_5555));
    send_item(enqueue_item(48'h8000_0000_00A5));
    // The queue is full now, so this put is dropped.
    send_item(enqueue_item(48'h7AAA_AAAA_AAAA));
    send_item(tick_item(1'b1));
    for (int i = 0; i < 4; i++) begin
      send_item(tick_item(1'b0));
    end
    send_item(tick_item(1'b0));
    send_item(enqueue_item(48'hAAAA_AAAA_AAAA));
    for (int i = 0; i < 12; i++) begin
      send_item(tick_item(i % 5 == 0));
    end
  endtask

  task automatic test_length_limits();
    set_config(8'd0, 8'd1, 8'd48);
    run_random(100, 15, 20);
    // Zero acts as one half-bit and anything above a full frame as a full frame.
    set_config(8'd3, 8'd0, 8'd255);
    run_random(100, 15, 20);
  endtask

  task automatic test_gap_saturation();
    set_config(8'd255, 8'd10, 8'd20);
    run_random(60, 30, 20);
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 3; k++) begin
      set_config(8'($urandom_range(12)), 8'($urandom_range(63)), 8'($urandom_range(63)));
      run_random(60, 12, 25);
    end
  endtask

  task automatic test_backpressure();
    set_config(8'd2, 8'd5, 8'd9);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    holdoff_req    = 60;
    for (int i = 0; i < 20; i++) begin
      send_item(random_item(30, 20));
    end
    // Pause until everything offered has come out, then continue.
    wait_for_results();
    for (int i = 0; i < 10; i++) begin
      send_item(random_item(30, 20));
    end
  endtask

  always @(posedge clk) begin
    if (holdoff_req > 0) begin
      holdoff_left = holdoff_req;
      holdoff_req  = 0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Outputs are settled at the falling edge; a transfer seen here completes at the next
  // rising edge.
  always @(negedge clk) begin : check_status
    irhft_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tx_status.size() == 0) begin
        $error("result transfer with no expected result pending");
        failures++;
      end else begin
        want = expected_tx_status.pop_front();
        if (out_data.ir_level !== want.ir_level) begin
          $error("ir_level: expected %0d, got %0d", want.ir_level, out_data.ir_level);
          failures++;
        end
        if (out_data.sending !== want.sending) begin
          $error("sending: expected %0d, got %0d", want.sending, out_data.sending);
          failures++;
        end
        if (out_data.held_start !== want.held_start) begin
          $error("held_start: expected %0d, got %0d", want.held_start, out_data.held_start);
          failures++;
        end
        if (out_data.put_accepted !== want.put_accepted) begin
          $error("put_accepted: expected %0d, got %0d",
                 want.put_accepted, out_data.put_accepted);
          failures++;
        end
        if (out_data.queue_count !== want.queue_count) begin
          $error("queue_count: expected %0d, got %0d", want.queue_count, out_data.queue_count);
          failures++;
        end
      end
    end
  end

  initial begin
    reset_tx_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_length_limits();
    test_gap_saturation();
    test_random_settings();
    test_backpressure();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (failures == 0 && expected_tx_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
